// ===== design/kom_pkg.sv =====
`timescale 1ns / 1ps
// Package for the k-mer overlap merge block: fixed widths and the records
// that travel between the pipeline stages. No dependencies.
package kom_pkg;

    localparam int KMER_W  = 64;
    localparam int LEN_W   = 6;
    localparam int OVL_W   = 5;
    localparam int MATCH_N = 32;

    localparam logic [LEN_W-1:0] KMER_LEN_RESET = 6'd8;

    // Stage A: masked k-mer and previous k-mer moved up to the top bits.
    typedef struct packed {
        logic [KMER_W-1:0] cur;
        logic [KMER_W-1:0] prev_al;
        logic              first;
        logic [LEN_W-1:0]  k;
    } kom_a_t;

    // Stage B: one bit per overlap length that matches.
    typedef struct packed {
        logic [KMER_W-1:0]  cur;
        logic [MATCH_N-1:0] match;
        logic [LEN_W-1:0]   k;
    } kom_b_t;

    // Stage C: the longest overlap that matches.
    typedef struct packed {
        logic [KMER_W-1:0] cur;
        logic [OVL_W-1:0]  overlap;
        logic [LEN_W-1:0]  k;
    } kom_c_t;

    // Stage D: the result as it leaves the block.
    typedef struct packed {
        logic [LEN_W-1:0]  count;
        logic [KMER_W-1:0] bases;
    } kom_d_t;

endpackage

// ===== design/kom_align.sv =====
`timescale 1ns / 1ps
// First pipeline stage: clamps k, masks the new k-mer and keeps the previous one.
// Depends on kom_pkg.
module kom_align #(
    parameter int MAX_K = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [kom_pkg::LEN_W-1:0] kmer_len,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [kom_pkg::KMER_W-1:0] in_kmer,
    input  logic                      in_first,
    output logic                      out_valid,
    input  logic                      out_ready,
    output kom_pkg::kom_a_t           out_data
);
    import kom_pkg::*;

    localparam logic [LEN_W-1:0] K_MAX = LEN_W'(MAX_K);

    logic [LEN_W-1:0]  k_eff;
    logic [KMER_W-1:0] mask;
    logic [KMER_W-1:0] cur_next;
    logic [KMER_W-1:0] prev_reg;
    logic [LEN_W-1:0]  gap;
    logic              valid_reg;
    kom_a_t            data_reg;
    kom_a_t            data_next;

    always_comb
    begin
        if (kmer_len == '0)
            k_eff = LEN_W'(1);
        else if (kmer_len > K_MAX)
            k_eff = K_MAX;
        else
            k_eff = kmer_len;
        mask     = ~({KMER_W{1'b1}} << {k_eff, 1'b0});
        cur_next = in_kmer & mask;
        // Bases 0..k-1 of the previous k-mer end up in the top 2k bits.
        gap      = LEN_W'(6'd32 - k_eff);
        data_next.cur     = cur_next;
        data_next.prev_al = prev_reg << {gap, 1'b0};
        data_next.first   = in_first;
        data_next.k       = k_eff;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            prev_reg  <= '0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
            if (in_valid)
                prev_reg <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ===== design/kom_match.sv =====
`timescale 1ns / 1ps
// Second pipeline stage: compares every proper suffix of the previous k-mer with the
// prefix of the same length of the new one. Depends on kom_pkg.
module kom_match (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kom_pkg::kom_a_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output kom_pkg::kom_b_t out_data
);
    import kom_pkg::*;

    logic [MATCH_N-1:0] match;
    logic               valid_reg;
    kom_b_t             data_reg;

    assign match[0] = 1'b0;

    for (genvar o = 1; o < MATCH_N; o++)
    begin : g_cmp
        assign match[o] = (LEN_W'(o) < in_data.k) && !in_data.first &&
                          (in_data.prev_al[KMER_W-1 -: 2*o] == in_data.cur[2*o-1:0]);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg.cur   <= in_data.cur;
            data_reg.match <= match;
            data_reg.k     <= in_data.k;
        end
    end

endmodule

// ===== design/kom_prio.sv =====
`timescale 1ns / 1ps
// Third pipeline stage: picks the longest matching overlap.
// Depends on kom_pkg.
module kom_prio (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kom_pkg::kom_b_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output kom_pkg::kom_c_t out_data
);
    import kom_pkg::*;

    logic [OVL_W-1:0] overlap;
    logic             valid_reg;
    kom_c_t           data_reg;

    always_comb
    begin
        overlap = '0;
        for (int o = 1; o < MATCH_N; o++)
        begin
            if (in_data.match[o])
                overlap = OVL_W'(o);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg.cur     <= in_data.cur;
            data_reg.overlap <= overlap;
            data_reg.k       <= in_data.k;
        end
    end

endmodule

// ===== design/kom_emit.sv =====
`timescale 1ns / 1ps
// Last pipeline stage: drops the overlapped bases and holds the result for
// the output channel. Depends on kom_pkg.
module kom_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kom_pkg::kom_c_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output kom_pkg::kom_d_t out_data
);
    import kom_pkg::*;

    logic   valid_reg;
    kom_d_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg.bases <= in_data.cur >> {in_data.overlap, 1'b0};
            data_reg.count <= in_data.k - LEN_W'(in_data.overlap);
        end
    end

endmodule

// ===== design/kmer_overlap_merge.sv =====
`timescale 1ns / 1ps
// Top level of the k-mer overlap merge: configuration register and the four
// pipeline stages. Depends on kom_pkg, kom_align, kom_match, kom_prio, kom_emit.
//
// Channel   Direction  Content
// s_axis    in         tdata[63:0] kmer, tuser[0] first_of_set
// m_axis    out        tdata[63:0] appended_bases, tdata[69:64] appended_count
// cfg       in         cfg_wr_data[5:0] kmer_len, written when cfg_wr_en is high
//
// Every k-mer passes four register stages: masking and alignment, the
// suffix/prefix compares, the longest-overlap priority pick, and the final
// shift, each one registered. One k-mer can be taken in every cycle while
// the output is not stalled. Each stage holds its data while the stage
// after it is full and stalled, so a stall on the output backs up stage
// by stage and nothing is dropped or repeated. Reset clears the valid
// bits and the previous k-mer (to zero) and sets kmer_len to 8.
module kmer_overlap_merge #(
    parameter int MAX_K = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: kmer_len
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] kmer
    input  logic        s_tuser,   // [0] first_of_set
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] appended_bases, [69:64] appended_count
);
    import kom_pkg::*;

    logic [LEN_W-1:0] kmer_len_reg;

    logic   a_valid;
    logic   a_ready;
    kom_a_t a_data;
    logic   b_valid;
    logic   b_ready;
    kom_b_t b_data;
    logic   c_valid;
    logic   c_ready;
    kom_c_t c_data;
    kom_d_t d_data;

    // The user must change the length only while the pipeline is empty; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kmer_len_reg <= KMER_LEN_RESET;
        else if (cfg_wr_en)
            kmer_len_reg <= cfg_wr_data;
    end

    kom_align #(
        .MAX_K(MAX_K)
    ) u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .kmer_len  (kmer_len_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kmer   (s_tdata),
        .in_first  (s_tuser),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_data  (a_data)
    );

    kom_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_data   (a_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    kom_prio u_prio (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_data   (b_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    kom_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (d_data)
    );

    // The count sits right above the bases; the top two bits pad to bytes.
    assign m_tdata = {2'b00, d_data};

endmodule
